FILE: src/aqhs_pkg.sv
// shared types, constants and the pulse brightness table of the hue smoother
package aqhs_pkg;

	// fixed-point fraction bits of the smoothed hue
	localparam int HUE_FRACTION_BITS = 16;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_GREEN_LIMIT    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RED_LIMIT      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GREEN_HUE      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_HUE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_GAIN = 3'd4;

	// register reset values
	localparam logic [15:0] GREEN_LIMIT_RST    = 16'd10;
	localparam logic [15:0] RED_LIMIT_RST      = 16'd200;
	localparam logic [15:0] GREEN_HUE_RST      = 16'd21845;
	localparam logic [15:0] WARMUP_HUE_RST     = 16'd43690;
	localparam logic [15:0] SMOOTHING_GAIN_RST = 16'd1311;

	// integer part of the smoothed hue after reset
	localparam logic [15:0] RESET_HUE = 16'd21845;

	// quotient bits of the gradient divide
	localparam int DIV_STEPS = 16;

	// pulse phase is kept as slot = phase / 10, five slots
	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] SLOT_LAST_WRAP = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_STEP      = 3'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic prod;
		logic div_step;
		logic quot;
		logic diff;
		logic mlo;
		logic mhi;
		logic commit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic need_div;
	} status_t;

	// rounded sine brightness for each phase slot
	function automatic logic [7:0] pulse_level(input logic [SLOT_W-1:0] slot);
		logic [7:0] lvl;
		case (slot)
			3'd0: lvl = 8'd128;
			3'd1: lvl = 8'd249;
			3'd2: lvl = 8'd202;
			3'd3: lvl = 8'd53;
			3'd4: lvl = 8'd6;
			default: lvl = 8'd128;
		endcase
		return lvl;
	endfunction

endpackage

FILE: src/aqhs_ctrl.sv
// controller state machine of the hue smoother
module aqhs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  aqhs_pkg::status_t status,
	output aqhs_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PROD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_QUOT = 3'd3;
	localparam logic [2:0] ST_DIFF = 3'd4;
	localparam logic [2:0] ST_MLO  = 3'd5;
	localparam logic [2:0] ST_MHI  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	localparam int CNT_W = $clog2(aqhs_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(aqhs_pkg::DIV_STEPS - 1);

	logic [2:0]       state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_nx = status.need_div ? ST_DIV : ST_DIFF;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) state_nx = ST_QUOT;
			end
			ST_QUOT: begin
				cmd.quot = 1'b1;
				state_nx = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_nx = ST_MLO;
			end
			ST_MLO: begin
				cmd.mlo = 1'b1;
				state_nx = ST_MHI;
			end
			ST_MHI: begin
				cmd.mhi = 1'b1;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state, divide step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_PROD))
		else $error("accepted request did not start processing");
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_QUOT))
		else $error("divide did not end after its last step");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_tready))
		else $error("result written over a pending result");
	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("output valid rose without a commit");
`endif

endmodule

FILE: src/aqhs_datapath.sv
// datapath of the hue smoother: registers, target divide, smoothing multiply, pulse phase
module aqhs_datapath #(
	parameter int FRAC_BITS = aqhs_pkg::HUE_FRACTION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [aqhs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic [15:0]                       air_index,
	input  logic                              warming,
	input  aqhs_pkg::cmd_t                    cmd,
	output aqhs_pkg::status_t                 status,
	output logic [15:0]                       hue,
	output logic                              pulsing,
	output logic [7:0]                        blue_level
);

	localparam int HW  = 16 + FRAC_BITS;   // smoothed hue width
	localparam int DW  = HW + 1;           // signed difference width
	localparam int HIW = DW - 16;          // upper part of the difference
	localparam int HPW = HIW + 17;         // upper partial product
	localparam int SW  = HPW + 1;          // update sum width

	// configuration
	logic [15:0] green_limit_q, red_limit_q, green_hue_q, warmup_hue_q, gain_q;

	// state
	logic [HW-1:0]                     smoothed_q;
	logic [aqhs_pkg::SLOT_W-1:0]       slot_q;

	// working registers
	logic [15:0]           idx_q;
	logic                  warm_q;
	logic [15:0]           target_q;
	logic [15:0]           rem_q;
	logic [15:0]           quo_q;
	logic signed [DW-1:0]  diff_q;
	logic [31:0]           lo_q;
	logic signed [HPW-1:0] hi_q;
	logic [15:0]           hue_q;
	logic                  pulsing_q;
	logic [7:0]            blue_q;

	logic                  above_red, at_green;
	logic [15:0]           num, span;
	logic [31:0]           prod_w;
	logic [16:0]           trial, trial_sub;
	logic                  trial_ge;
	logic [DW-1:0]         diff_w;
	logic signed [SW-1:0]  delta_w, sum_w;
	logic [HW-1:0]         new_hue_w;
	logic [aqhs_pkg::SLOT_W-1:0] slot_nx;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_limit_q <= aqhs_pkg::GREEN_LIMIT_RST;
			red_limit_q   <= aqhs_pkg::RED_LIMIT_RST;
			green_hue_q   <= aqhs_pkg::GREEN_HUE_RST;
			warmup_hue_q  <= aqhs_pkg::WARMUP_HUE_RST;
			gain_q        <= aqhs_pkg::SMOOTHING_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				aqhs_pkg::REG_GREEN_LIMIT:    green_limit_q <= cfg_data;
				aqhs_pkg::REG_RED_LIMIT:      red_limit_q   <= cfg_data;
				aqhs_pkg::REG_GREEN_HUE:      green_hue_q   <= cfg_data;
				aqhs_pkg::REG_WARMUP_HUE:     warmup_hue_q  <= cfg_data;
				aqhs_pkg::REG_SMOOTHING_GAIN: gain_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// index classification and gradient product
	assign above_red       = idx_q >= red_limit_q;
	assign at_green        = idx_q <= green_limit_q;
	assign status.need_div = !warm_q && !above_red && !at_green;
	assign num    = idx_q - green_limit_q;
	assign span   = red_limit_q - green_limit_q;
	assign prod_w = {16'd0, green_hue_q} * {16'd0, num};

	// one restoring divide step, product fits since quotient < 2^16
	assign trial     = {rem_q, quo_q[15]};
	assign trial_sub = trial - {1'b0, span};
	assign trial_ge  = trial >= {1'b0, span};

	// signed difference between target and smoothed hue
	assign diff_w = DW'({target_q, {FRAC_BITS{1'b0}}}) - DW'(smoothed_q);

	// floor of diff * gain / 2^16 from two partial products
	assign delta_w   = SW'(hi_q) + $signed({{(SW-16){1'b0}}, lo_q[31:16]});
	assign sum_w     = $signed({3'b000, smoothed_q}) + delta_w;
	assign new_hue_w = sum_w[HW-1:0];

	// next pulse slot: phase + 20 mod 50
	assign slot_nx = (slot_q >= aqhs_pkg::SLOT_LAST_WRAP) ? slot_q - aqhs_pkg::SLOT_LAST_WRAP
		: slot_q + aqhs_pkg::SLOT_STEP;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= air_index;
			warm_q <= warming;
		end
		if (cmd.prod) begin
			rem_q <= prod_w[31:16];
			quo_q <= prod_w[15:0];
			if (warm_q) target_q <= warmup_hue_q;
			else if (above_red) target_q <= 16'd0;
			else target_q <= green_hue_q;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[15:0] : trial[15:0];
			quo_q <= {quo_q[14:0], trial_ge};
		end
		if (cmd.quot) target_q <= green_hue_q - quo_q;
		if (cmd.diff) diff_q <= $signed(diff_w);
		if (cmd.mlo) lo_q <= {16'd0, diff_q[15:0]} * {16'd0, gain_q};
		if (cmd.mhi) hi_q <= $signed(diff_q[DW-1:16]) * $signed({1'b0, gain_q});
		if (cmd.commit) begin
			hue_q     <= new_hue_w[HW-1:FRAC_BITS];
			pulsing_q <= warm_q;
			blue_q    <= warm_q ? aqhs_pkg::pulse_level(slot_nx) : 8'd0;
		end
	end

	// smoothed hue and pulse phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= {aqhs_pkg::RESET_HUE, {FRAC_BITS{1'b0}}};
			slot_q     <= '0;
		end else if (cmd.commit) begin
			smoothed_q <= new_hue_w;
			if (warm_q) slot_q <= slot_nx;
		end
	end

	assign hue        = hue_q;
	assign pulsing    = pulsing_q;
	assign blue_level = blue_q;

endmodule

FILE: src/air_quality_hue_smoother_unit.sv
// top level of the air-quality hue smoother
// One request per update tick: air index in s_tdata, warm-up flag in s_tuser. Each request
// gives one result: integer hue of the smoothed Q(16.FRAC) hue, pulsing flag and blue level.
// When the target needs no divide (warming, index at or below green_limit, or at or above
// red_limit), a request runs through the product, difference, low and high multiply states
// to the commit; when the index lies on the gradient, the 16-step restoring divider and a
// quotient state come between product and difference. The commit waits for a free output.
// The next request is taken once the current one has been placed in the output register,
// even while that result still waits for m_tready.
module air_quality_hue_smoother_unit #(
	parameter int HUE_FRACTION_BITS = aqhs_pkg::HUE_FRACTION_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [aqhs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                      cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // [15:0] air_index
	input  logic                             s_tuser,   // [0] warming
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,   // [15:0] hue, [23:16] blue_level
	output logic                             m_tuser    // [0] pulsing
);

	aqhs_pkg::cmd_t    cmd;
	aqhs_pkg::status_t status;
	logic [15:0]       hue;
	logic [7:0]        blue_level;

	// sequencing
	aqhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and state
	aqhs_datapath #(
		.FRAC_BITS (HUE_FRACTION_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.air_index  (s_tdata),
		.warming    (s_tuser),
		.cmd        (cmd),
		.status     (status),
		.hue        (hue),
		.pulsing    (m_tuser),
		.blue_level (blue_level)
	);

	assign m_tdata = {blue_level, hue};

endmodule
